// ===== src/dfd_pkg.sv =====
// ----------------------------------------------------------------------------
// dfd_pkg
// Types and constants shared by the drive fault detector modules.
// ----------------------------------------------------------------------------
package dfd_pkg;

  // Configuration bus geometry: 64-bit data, registers on 8-byte strides
  localparam int unsigned DataW = 64;
  localparam int unsigned AddrW = 6;

  // Operation codes carried by an input item
  typedef enum logic [1:0] {
    OP_FAST  = 2'd0,
    OP_SLOW  = 2'd1,
    OP_CLEAR = 2'd2
  } op_e;

  // Register indexes (byte address / 8)
  typedef enum logic [2:0] {
    REG_OC_TRIP     = 3'd0,
    REG_OV_TRIP     = 3'd1,
    REG_UV_TRIP     = 3'd2,
    REG_QUALIFY     = 3'd3,
    REG_OT_TRIP     = 3'd4,
    REG_OL_CONT     = 3'd5,
    REG_OL_TRIP_LVL = 3'd6
  } reg_idx_e;

  // Fault flag bit positions
  localparam int unsigned FlagOcA   = 0;
  localparam int unsigned FlagOcB   = 1;
  localparam int unsigned FlagOcC   = 2;
  localparam int unsigned FlagOcMag = 3;
  localparam int unsigned FlagOv    = 4;
  localparam int unsigned FlagUv    = 5;
  localparam int unsigned FlagHw    = 6;
  localparam int unsigned FlagShort = 7;
  localparam int unsigned FlagOl    = 8;
  localparam int unsigned FlagOt    = 9;
  localparam int unsigned NumFlags  = 10;

  // Register reset values
  localparam logic [14:0]        OcTripRst    = 15'h7FFF;
  localparam logic [15:0]        OvTripRst    = 16'hFFFF;
  localparam logic [15:0]        UvTripRst    = 16'h0000;
  localparam logic [15:0]        QualifyRst   = 16'd20;
  localparam logic signed [11:0] OtTripRst    = 12'sd1000;
  localparam logic [30:0]        OlContRst    = 31'd0;
  localparam logic [47:0]        OlTripLvlRst = 48'hFFFF_FFFF_FFFF;

  localparam logic [15:0] CntMax = 16'hFFFF;
  localparam logic [47:0] AccMax = 48'hFFFF_FFFF_FFFF;

  typedef struct packed {
    logic [1:0]          op;
    logic signed [15:0]  phase_a;
    logic signed [15:0]  phase_b;
    logic signed [15:0]  phase_c;
    logic [14:0]         current_mag;
    logic [15:0]         dc_voltage;
    logic signed [11:0]  temperature;
    logic                trip_zone;
    logic                device_ok;
  } in_item_t;

  typedef struct packed {
    logic [NumFlags-1:0] fault_flags;
    logic                any_fault;
    logic                record_strobe;
    logic [14:0]         record_current;
    logic [15:0]         record_vdc;
  } out_item_t;

  typedef struct packed {
    logic [14:0]         oc_trip;
    logic [15:0]         ov_trip;
    logic [15:0]         uv_trip;
    logic [15:0]         qualify_count;
    logic signed [11:0]  ot_trip;
    logic [30:0]         ol_continuous_sq;
    logic [47:0]         ol_trip_level;
  } cfg_t;

endpackage

// ===== src/drive_fault_detector_top.sv =====
// ----------------------------------------------------------------------------
// drive_fault_detector_top
// Pipeline: an accepted item passes through the input register with the
//   magnitude square, then the result register.
// Throughput: one item per cycle; a stalled result register holds the pipe.
// Reset: asynchronous, active low; clears flags, counters, the accumulator,
//   and loads the configuration registers with their defaults.
// ----------------------------------------------------------------------------
module drive_fault_detector_top
  import dfd_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  in_item_t         in_item_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output out_item_t        out_item_o,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [DataW-1:0] pwdata,
  output logic [DataW-1:0] prdata,
  output logic             pready
);

  cfg_t        cfg;
  logic        s1_valid_q, s1_valid_d;
  in_item_t    s1_item_q;
  logic [29:0] s1_sq_q;
  logic        out_valid_q, out_valid_d;
  out_item_t   out_item_q;
  out_item_t   res;
  logic        out_free;
  logic        fire;
  logic        in_acc;

  assign pready = 1'b1;

  dfd_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg_o   (cfg)
  );

  // Handshake: result slot free when empty or being taken
  assign out_free   = !out_valid_q || !out_stall_i;
  assign fire       = s1_valid_q && out_free;
  assign in_stall_o = s1_valid_q && !out_free;
  assign in_acc     = in_valid_i && !in_stall_o;

  assign s1_valid_d  = in_acc ? 1'b1 : (fire ? 1'b0 : s1_valid_q);
  assign out_valid_d = fire ? 1'b1 : (out_free ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Capture the item and square its magnitude
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_item_q <= in_item_i;
      s1_sq_q   <= {15'd0, in_item_i.current_mag} * {15'd0, in_item_i.current_mag};
    end
  end

  dfd_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fire_i   (fire),
    .item_i   (s1_item_q),
    .mag_sq_i (s1_sq_q),
    .cfg_i    (cfg),
    .res_o    (res)
  );

  // Hold the result until taken
  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_item_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

// ===== src/dfd_cfg.sv =====
// ----------------------------------------------------------------------------
// dfd_cfg
// Configuration register file behind a simple APB-style slave port.
// ----------------------------------------------------------------------------
module dfd_cfg
  import dfd_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [DataW-1:0] pwdata,
  output logic [DataW-1:0] prdata,
  output cfg_t             cfg_o
);

  cfg_t       cfg_q, cfg_d;
  logic       wr_en;
  logic [2:0] idx;

  assign idx   = paddr[AddrW-1:3];
  assign wr_en = psel & penable & pwrite;

  // Decode the write
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (reg_idx_e'(idx))
        REG_OC_TRIP:     cfg_d.oc_trip          = pwdata[14:0];
        REG_OV_TRIP:     cfg_d.ov_trip          = pwdata[15:0];
        REG_UV_TRIP:     cfg_d.uv_trip          = pwdata[15:0];
        REG_QUALIFY:     cfg_d.qualify_count    = pwdata[15:0];
        REG_OT_TRIP:     cfg_d.ot_trip          = pwdata[11:0];
        REG_OL_CONT:     cfg_d.ol_continuous_sq = pwdata[30:0];
        REG_OL_TRIP_LVL: cfg_d.ol_trip_level    = pwdata[47:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.oc_trip          <= OcTripRst;
      cfg_q.ov_trip          <= OvTripRst;
      cfg_q.uv_trip          <= UvTripRst;
      cfg_q.qualify_count    <= QualifyRst;
      cfg_q.ot_trip          <= OtTripRst;
      cfg_q.ol_continuous_sq <= OlContRst;
      cfg_q.ol_trip_level    <= OlTripLvlRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Read back the addressed register, zero-extended
  always_comb begin
    unique case (reg_idx_e'(idx))
      REG_OC_TRIP:     prdata = {{(DataW-15){1'b0}}, cfg_q.oc_trip};
      REG_OV_TRIP:     prdata = {{(DataW-16){1'b0}}, cfg_q.ov_trip};
      REG_UV_TRIP:     prdata = {{(DataW-16){1'b0}}, cfg_q.uv_trip};
      REG_QUALIFY:     prdata = {{(DataW-16){1'b0}}, cfg_q.qualify_count};
      REG_OT_TRIP:     prdata = {{(DataW-12){1'b0}}, cfg_q.ot_trip};
      REG_OL_CONT:     prdata = {{(DataW-31){1'b0}}, cfg_q.ol_continuous_sq};
      REG_OL_TRIP_LVL: prdata = {{(DataW-48){1'b0}}, cfg_q.ol_trip_level};
      default:         prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

// ===== src/dfd_core.sv =====
// ----------------------------------------------------------------------------
// dfd_core
// Fault state (latched flags, qualifying counters, overload accumulator) and
// the combinational check logic that computes one result per item.
// ----------------------------------------------------------------------------
module dfd_core
  import dfd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        fire_i,
  input  in_item_t    item_i,
  input  logic [29:0] mag_sq_i,
  input  cfg_t        cfg_i,
  output out_item_t   res_o
);

  logic [NumFlags-1:0] flags_q, flags_d;
  logic [15:0]         ov_cnt_q, ov_cnt_d;
  logic [15:0]         uv_cnt_q, uv_cnt_d;
  logic [15:0]         ot_cnt_q, ot_cnt_d;
  logic [47:0]         acc_q, acc_d;

  logic [16:0] abs_a, abs_b, abs_c;
  logic [16:0] oc_ext;
  logic        mag_oc;
  logic [15:0] ov_next, uv_next, ot_next;
  logic [49:0] acc_sum;
  logic [47:0] acc_clamped;

  // Absolute value of a phase sample; full scale negative gives 32768
  function automatic logic [16:0] abs17(input logic signed [15:0] v);
    logic [16:0] ext;
    ext = {v[15], v};
    return v[15] ? (~ext + 17'd1) : ext;
  endfunction

  // Up/down qualifying counter, saturating at full scale
  function automatic logic [15:0] qualify(input logic [15:0] cnt, input logic cond);
    logic [15:0] r;
    r = cnt;
    if (cond) begin
      if (cnt != CntMax) r = cnt + 16'd1;
    end else if (cnt != 16'd0) begin
      r = cnt - 16'd1;
    end
    return r;
  endfunction

  assign abs_a  = abs17(item_i.phase_a);
  assign abs_b  = abs17(item_i.phase_b);
  assign abs_c  = abs17(item_i.phase_c);
  assign oc_ext = {2'b00, cfg_i.oc_trip};
  assign mag_oc = item_i.current_mag > cfg_i.oc_trip;

  assign ov_next = qualify(ov_cnt_q, item_i.dc_voltage > cfg_i.ov_trip);
  assign uv_next = qualify(uv_cnt_q, item_i.dc_voltage < cfg_i.uv_trip);
  assign ot_next = qualify(ot_cnt_q,
                           $signed(item_i.temperature) > $signed(cfg_i.ot_trip));

  // I-squared-t step: add the square, remove the continuous level, clamp
  assign acc_sum = {2'b00, acc_q} + {20'd0, mag_sq_i} - {19'd0, cfg_i.ol_continuous_sq};
  always_comb begin
    if (acc_sum[49]) begin
      acc_clamped = '0;
    end else if (acc_sum[48]) begin
      acc_clamped = AccMax;
    end else begin
      acc_clamped = acc_sum[47:0];
    end
  end

  // Run the selected check
  always_comb begin
    flags_d  = flags_q;
    ov_cnt_d = ov_cnt_q;
    uv_cnt_d = uv_cnt_q;
    ot_cnt_d = ot_cnt_q;
    acc_d    = acc_q;
    res_o    = '0;
    unique case (op_e'(item_i.op))
      OP_FAST: begin
        if (abs_a > oc_ext) flags_d[FlagOcA] = 1'b1;
        if (abs_b > oc_ext) flags_d[FlagOcB] = 1'b1;
        if (abs_c > oc_ext) flags_d[FlagOcC] = 1'b1;
        if (mag_oc) begin
          flags_d[FlagOcMag]   = 1'b1;
          res_o.record_strobe  = 1'b1;
          res_o.record_current = item_i.current_mag;
          res_o.record_vdc     = item_i.dc_voltage;
        end
        ov_cnt_d = ov_next;
        uv_cnt_d = uv_next;
        if (ov_next >= cfg_i.qualify_count) flags_d[FlagOv] = 1'b1;
        if (uv_next >= cfg_i.qualify_count) flags_d[FlagUv] = 1'b1;
        if (item_i.trip_zone) flags_d[FlagHw] = 1'b1;
        if (!item_i.device_ok) flags_d[FlagShort] = 1'b1;
      end
      OP_SLOW: begin
        acc_d = acc_clamped;
        if (acc_clamped > cfg_i.ol_trip_level) begin
          flags_d[FlagOl] = 1'b1;
          acc_d           = '0;
        end
        ot_cnt_d = ot_next;
        if (ot_next >= cfg_i.qualify_count) flags_d[FlagOt] = 1'b1;
      end
      OP_CLEAR: flags_d = '0;
      default: ;
    endcase
    res_o.fault_flags = flags_d;
    res_o.any_fault   = |flags_d;
  end

  // Commit state when the item moves into the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flags_q  <= '0;
      ov_cnt_q <= '0;
      uv_cnt_q <= '0;
      ot_cnt_q <= '0;
      acc_q    <= '0;
    end else if (fire_i) begin
      flags_q  <= flags_d;
      ov_cnt_q <= ov_cnt_d;
      uv_cnt_q <= uv_cnt_d;
      ot_cnt_q <= ot_cnt_d;
      acc_q    <= acc_d;
    end
  end

endmodule

// ===== src/dfd_checker.sv =====
// ----------------------------------------------------------------------------
// dfd_checker
// Port-level checks on the drive fault detector results, bound to the top.
// ----------------------------------------------------------------------------
module dfd_checker
  import dfd_pkg::*;
(
  input logic             clk_i,
  input logic             rst_ni,
  input logic             out_valid_o,
  input logic             out_stall_i,
  input out_item_t        out_item_o,
  input logic             pready
);

  // Summary bit agrees with the flag vector
  a_any_fault: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_item_o.any_fault == (out_item_o.fault_flags != '0)))
    else $error("any_fault disagrees with fault_flags");

  // Record fields are zero without a strobe
  a_record_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_item_o.record_strobe) |->
      (out_item_o.record_current == '0 && out_item_o.record_vdc == '0))
    else $error("record fields set without strobe");

  // A record comes only with the magnitude overcurrent flag latched
  a_record_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_item_o.record_strobe) |->
      (out_item_o.fault_flags[FlagOcMag] && out_item_o.any_fault))
    else $error("record strobe without magnitude overcurrent flag");

  // Configuration port never waits
  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pready)
    else $error("pready dropped");

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(out_item_o)))
    else $error("stalled result changed");

endmodule

bind drive_fault_detector_top dfd_checker u_dfd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_item_o  (out_item_o),
  .pready      (pready)
);
